@@ design/bs3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs3_pkg: shared types and constants for the 3x3 box smoothing filter
// Transaction payloads, register indexes, arithmetic widths and the
// reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
package bs3_pkg;

  localparam int PIX_W      = 16;
  localparam int FW_W       = 11;   // frame_width register
  localparam int FH_W       = 16;   // frame_height register
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1;

  localparam logic MODE_PIXEL = 1'b0;

  localparam int IN_ROW_W    = FH_W + 1;  // runs two rows past the frame while draining
  localparam int COL_SUM_W   = 18;        // three pixels
  localparam int WIN_SUM_W   = 20;        // nine pixels
  localparam int CNT_W       = 4;         // divisor 1..9
  localparam int RECIP_SHIFT = 24;        // exact for any 20-bit sum, divisor <= 9
  localparam int RECIP_W     = 25;
  localparam int PROD_W      = WIN_SUM_W + RECIP_W;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } src_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_end;
  } res_item_t;

  // ceil(2^24 / cnt) for the divisors a clipped 3x3 window can have
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194304;
      4'd6:    m = 25'd2796203;
      4'd9:    m = 25'd1864136;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ design/bs3_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs3_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bs3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/box_smooth_3x3_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_smooth_3x3_unit: streaming 3x3 box (mean) filter
// Raster-order greyscale pixels in, rounded neighborhood means out, lagging
// the input by frame_width + 1 pixels. Flush transactions drain the tail.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   src      | in        | src_valid/src_stall  | src_item  (mode, pixel)
//   res      | out       | res_valid/res_stall  | res_item  (smoothed, frame_end)
//   cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// One transaction at a time. A pixel that yields no result passes a RAM read,
// then column update/write-back; one that yields a result passes on through
// window sum, reciprocal multiply and rounding. The registered read of the two
// row RAMs sets the step length. On the first flush of a single-row frame the
// sequencer runs an extra step (ST_FETCH, ST_STEP) to fill the window.
// rst is synchronous; the row RAMs are not cleared.
// res_stall holds the finished result in the output register; src is
// accepted again as soon as the result is parked there.
// ----------------------------------------------------------------------------
module box_smooth_3x3_unit
  import bs3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel input
  input  logic                  src_valid,
  output logic                  src_stall,
  input  src_item_t             src_item,
  // result output
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res_item,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // column index width and lag counter width (lag reaches width + 1)
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = $clog2(MAX_WIDTH + 2);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;  // re-read row RAMs for a fill step
  localparam logic [2:0] ST_STEP  = 3'd2;  // column update, RAM write-back
  localparam logic [2:0] ST_SUM   = 3'd3;  // window sum and divisor
  localparam logic [2:0] ST_DIV   = 3'd4;  // reciprocal multiply
  localparam logic [2:0] ST_RND   = 3'd5;  // remainder, rounding, output

  logic [2:0]          state;

  // configuration registers
  logic [FW_W-1:0]     frame_width;
  logic [FH_W-1:0]     frame_height;

  // position of the next pixel step (real or drain) and of the next result
  logic [CW-1:0]       in_col;
  logic [IN_ROW_W-1:0] in_row;
  logic [CW-1:0]       out_col;
  logic [FH_W-1:0]     out_row;
  logic [AW-1:0]       ahead;        // steps taken minus results given

  // transaction payload
  logic [PIX_W-1:0]    pix_reg;
  logic                is_drain;

  // row RAM read data: a = previous row, b = row before that
  logic [PIX_W-1:0]    a_q;
  logic [PIX_W-1:0]    b_q;

  // window: three column sums, row counts of the two newer columns
  logic [COL_SUM_W-1:0] win_sum [3];
  logic [1:0]           win_rc1;
  logic [1:0]           win_rc2;

  // divider path
  logic [WIN_SUM_W-1:0] sum_reg;
  logic [CNT_W-1:0]     cnt_reg;
  logic                 fe_reg;
  logic [PIX_W-1:0]     q_reg;

  // effective frame geometry
  logic [CW-1:0]       w_last;
  logic [FH_W-1:0]     h_last;
  logic [AW-1:0]       ahead_target;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(32'(frame_width) - 32'd1);
    end
    h_last       = (frame_height == '0) ? '0 : frame_height - 16'd1;
    ahead_target = AW'(w_last) + AW'(2);
  end

  logic src_accept;
  logic done;
  logic step_go;
  logic emit_now;
  logic frame_last;
  logic out_free;

  assign src_stall  = (state != ST_IDLE);
  assign src_accept = src_valid && !src_stall;
  // all pixels of the frame are in: every item drains one result
  assign done       = (in_row > IN_ROW_W'(h_last));
  assign step_go    = done || (src_item.mode == MODE_PIXEL);
  assign emit_now   = (ahead == ahead_target);
  assign frame_last = (out_row == h_last) && (out_col == w_last);
  assign out_free   = !res_valid || !res_stall;

  // column from the current step, clipped at the top and bottom frame edges;
  // its center row is one above the step's row
  logic                 top_ok;
  logic                 bot_ok;
  logic [COL_SUM_W-1:0] col_sum;
  logic [1:0]           col_rc;

  always_comb begin
    top_ok  = (in_row >= IN_ROW_W'(2));
    bot_ok  = (in_row <= IN_ROW_W'(h_last));
    col_sum = COL_SUM_W'(a_q)
            + (top_ok ? COL_SUM_W'(b_q) : '0)
            + (bot_ok ? COL_SUM_W'(pix_reg) : '0);
    col_rc  = 2'd1 + 2'(top_ok) + 2'(bot_ok);
  end

  // window sum, clipped at the left and right frame edges
  logic                 left_ok;
  logic                 right_ok;
  logic [WIN_SUM_W-1:0] win_total;
  logic [1:0]           win_cc;

  always_comb begin
    left_ok   = (out_col != '0);
    right_ok  = (out_col != w_last);
    win_total = WIN_SUM_W'(win_sum[1])
              + (left_ok  ? WIN_SUM_W'(win_sum[0]) : '0)
              + (right_ok ? WIN_SUM_W'(win_sum[2]) : '0);
    win_cc    = 2'd1 + 2'(left_ok) + 2'(right_ok);
  end

  // quotient estimate is exact; remainder picks the rounding
  logic [PROD_W-1:0]    quot_prod;
  logic [WIN_SUM_W-1:0] back_prod;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W:0]       rem_x2;
  logic                 round_up;
  logic [PIX_W-1:0]     mean;

  always_comb begin
    quot_prod = PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));
    back_prod = WIN_SUM_W'(q_reg) * WIN_SUM_W'(cnt_reg);
    rem       = CNT_W'(sum_reg - back_prod);
    rem_x2    = {rem, 1'b0};
    // exact half goes to the odd neighbor
    round_up  = (rem_x2 > (CNT_W + 1)'(cnt_reg))
             || ((rem_x2 == (CNT_W + 1)'(cnt_reg)) && (rem != '0) && !q_reg[0]);
    mean      = q_reg + PIX_W'(round_up);
  end

  // row line buffers: read at in_col every cycle, written back in ST_STEP
  logic ram_we;
  assign ram_we = (state == ST_STEP);

  bs3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col),
    .wdata (pix_reg),
    .raddr (in_col),
    .rdata (a_q)
  );

  bs3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col),
    .wdata (a_q),
    .raddr (in_col),
    .rdata (b_q)
  );

  // sequencer, position counters, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      ahead        <= '0;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else begin
      case (state)
        ST_IDLE: begin
          if (src_accept && step_go) begin
            state <= ST_STEP;
          end
        end
        ST_FETCH: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (in_col == w_last) begin
            in_col <= '0;
            in_row <= in_row + IN_ROW_W'(1);
          end else begin
            in_col <= in_col + CW'(1);
          end
          if (emit_now) begin
            state <= ST_SUM;
          end else begin
            ahead <= ahead + AW'(1);
            // drain keeps stepping until the window reaches the next result
            state <= is_drain ? ST_FETCH : ST_IDLE;
          end
        end
        ST_SUM: begin
          if (frame_last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            ahead   <= '0;
          end else if (out_col == w_last) begin
            out_col <= '0;
            out_row <= out_row + FH_W'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_RND;
        end
        ST_RND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // any register write restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
          default: ;
        endcase
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        ahead   <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (src_accept) begin
      pix_reg  <= src_item.pixel;
      is_drain <= done;
    end
    if (state == ST_STEP) begin
      win_sum[0] <= win_sum[1];
      win_sum[1] <= win_sum[2];
      win_sum[2] <= col_sum;
      win_rc1    <= win_rc2;
      win_rc2    <= col_rc;
    end
    if (state == ST_SUM) begin
      sum_reg <= win_total;
      cnt_reg <= CNT_W'(win_rc1) * CNT_W'(win_cc);
      fe_reg  <= frame_last;
    end
    if (state == ST_DIV) begin
      q_reg <= PIX_W'(quot_prod >> RECIP_SHIFT);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_RND && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RND && out_free) begin
      res_item.smoothed  <= mean;
      res_item.frame_end <= fe_reg;
    end
  end

  // a new result only ever comes out of the rounding step
  a_res_from_rnd: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_RND))
    else $error("result appeared outside the rounding step");

  // pending lag never exceeds width + 1 pixels
  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    ahead <= ahead_target)
    else $error("pixel lag exceeded width + 1");

  // the frame's last result returns all position counters to the start
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && frame_last) |=> (in_row == '0 && in_col == '0 && ahead == '0))
    else $error("counters not restarted after the last result of a frame");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 box smoothing filter
// A directed table covers clamped width/height values, rounding of exact
// halves, flush corner cases and restart by register write.
// A random part follows with many small frames, a few cut-short frames and
// one max-width and one max-height partial frame. Every accepted pixel
// transaction runs through a local neighborhood-mean predictor; results are
// compared in order against the queue of expected means.
// ----------------------------------------------------------------------------
module tb_top;
  import bs3_pkg::*;

  localparam int MAX_W = 1024;
  // delay line: two rows plus the 3x3 window registers
  localparam int RING = 2 * MAX_W + 6;
  // a no-result transaction may still be in flight after the last result;
  // worst case is the window fill on a single-row frame
  localparam int SETTLE_CYCLES = 2 * MAX_W + 16;
  localparam int RANDOM_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic MODE_FLUSH = ~MODE_PIXEL;
  localparam res_item_t NO_RES = '0;

  // what the directed table asks for on each row
  typedef enum logic [1:0] {STEP_GEOM, STEP_PIXEL, STEP_FLUSH} step_e;
  // how a transaction's result is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_e;

  typedef struct {
    step_e            kind;
    logic [PIX_W-1:0] a;     // pixel, or width for STEP_GEOM
    logic [FH_W-1:0]  b;     // height for STEP_GEOM
    chk_e             chk;
    res_item_t        want;
  } script_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; the bench-driven ones are known from time zero
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  src_valid = 1'b0;
  logic                  src_stall;
  src_item_t             src_item = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_item_t             res_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // travel with the pixel transaction so the checker knows how to score it
  chk_e                  tag_chk = CHK_MODEL;
  res_item_t             tag_exp = '0;

  int                    src_idle_pct = 25;
  int                    sink_idle_pct = 75;
  int                    fail_count = 0;
  int unsigned           cycle_count = 0;

  res_item_t             expected_means[$];
  script_row_t           script[$];

  box_smooth_3x3_unit #(.MAX_WIDTH(MAX_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Neighborhood-mean predictor: own copy of geometry, counters and pixels
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] line_mem [RING];
  logic [FW_W-1:0]  fw;
  logic [FH_W-1:0]  fh;
  int unsigned      in_col, in_row, out_pos;

  function automatic int unsigned eff_w();
    if (fw == '0) return 1;          // zero width acts as one pixel
    if (fw > MAX_W) return MAX_W;    // clamp to line buffer depth
    return fw;
  endfunction

  function automatic int unsigned eff_h();
    return (fh == '0) ? 1 : fh;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endfunction

  // round to nearest; an exact half goes to the odd neighbor
  function automatic logic [PIX_W-1:0] rounded_mean(int unsigned sum, int unsigned cnt);
    int unsigned q, r;
    q = sum / cnt;
    r = sum % cnt;
    if (2 * r > cnt) q++;
    else if (2 * r == cnt && r != 0 && !q[0]) q++;
    return PIX_W'(q);
  endfunction

  // mean of the clipped 3x3 window around the next output position
  function automatic res_item_t next_mean();
    int unsigned w, h, n, p, r, c, sum, cnt;
    int          dr, dc, rr, cc;
    res_item_t   o;
    w = eff_w();
    h = eff_h();
    n = w * h;
    p = out_pos;
    r = p / w;
    c = p % w;
    sum = 0;
    cnt = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = int'(r) + dr;
        cc = int'(c) + dc;
        if (rr < 0 || cc < 0 || rr >= int'(h) || cc >= int'(w)) continue;
        sum += line_mem[(rr * w + cc) % RING];
        cnt++;
      end
    end
    o.smoothed = rounded_mean(sum, cnt);
    o.frame_end = (p + 1 >= n);
    if (p + 1 >= n) restart_frame();
    else out_pos = p + 1;
    return o;
  endfunction

  // one accepted transaction: store the pixel, emit a mean if one is due
  task automatic mean_step(input src_item_t it, output bit got, output res_item_t o);
    int unsigned w, h, n, idx;
    bit          frame_done;
    w = eff_w();
    h = eff_h();
    n = w * h;
    frame_done = (in_row >= h);
    got = 1'b0;
    o = '0;
    if (it.mode == MODE_PIXEL && !frame_done) begin
      idx = in_row * w + in_col;
      line_mem[idx % RING] = it.pixel;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      idx++;
      // output lags input by width + 1 pixels
      if (idx - out_pos > w + 1) begin
        got = 1'b1;
        o = next_mean();
      end
    end else if (frame_done && out_pos < n) begin
      // flush, or a pixel past the frame end, drains one pending mean
      got = 1'b1;
      o = next_mean();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checker: predicts at input acceptance, compares at output acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    bit        got;
    res_item_t predicted;
    res_item_t want;
    if (rst) begin
      fw = FRAME_WIDTH_RST;
      fh = FRAME_HEIGHT_RST;
      restart_frame();
      expected_means.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fw = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: fh = cfg_data[FH_W-1:0];
          default: ;
        endcase
        // any register write restarts the frame, pending means are dropped
        restart_frame();
      end
      if (src_valid && !src_stall) begin
        mean_step(src_item, got, predicted);
        case (tag_chk)
          CHK_MODEL: if (got) expected_means.push_back(predicted);
          CHK_VALUE: expected_means.push_back(tag_exp);
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (expected_means.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result smoothed=%0d frame_end=%0b",
                     $realtime, res_item.smoothed, res_item.frame_end);
        end else begin
          want = expected_means.pop_front();
          if (res_item.smoothed !== want.smoothed ||
              res_item.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch smoothed exp=%0d got=%0d, frame_end exp=%0b got=%0b",
                       $realtime, want.smoothed, res_item.smoothed,
                       want.frame_end, res_item.frame_end);
          end
        end
      end
    end
  end

  // receiver back-pressure; the rate follows the current idling regime
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // biased toward the ends of the range so every pixel bit toggles
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(15));
      3:       return PIX_W'(16'hFFFF - $urandom_range(15));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // one src transaction, with random idle cycles ahead of it; returns at the
  // edge where it was accepted, valid still high
  task automatic send(logic mode, logic [PIX_W-1:0] pix, chk_e chk, res_item_t want);
    src_item_t it;
    it.mode = mode;
    it.pixel = pix;
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item <= it;
    tag_chk <= chk;
    tag_exp <= want;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  // rewrite both registers once the block has gone quiet
  task automatic write_geometry(logic [FW_W-1:0] w, logic [FH_W-1:0] h);
    logic [CFG_DATA_W-1:0] wd;
    wd = CFG_DATA_W'($urandom);   // bits above the width field must be ignored
    wd[FW_W-1:0] = w;
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= wd;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(step_e kind, logic [PIX_W-1:0] a, logic [FH_W-1:0] b,
                         chk_e chk, logic [PIX_W-1:0] sm, logic fe);
    script_row_t row;
    row.kind = kind;
    row.a = a;
    row.b = b;
    row.chk = chk;
    row.want.smoothed = sm;
    row.want.frame_end = fe;
    script.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned items, phase, wr, hr, ew, eh, n, frames, cut_at, pend, k;
    items = 0;

    // width 0 and height 0 both act as 1: a one-pixel frame
    add_row(STEP_GEOM,  16'd0, 16'd0, CHK_NONE, 0, 0);
    add_row(STEP_FLUSH, 16'd0, 0, CHK_NONE, 0, 0);            // nothing pending
    add_row(STEP_PIXEL, 16'hFFFF, 0, CHK_NONE, 0, 0);
    add_row(STEP_PIXEL, 16'd0, 0, CHK_VALUE, 16'hFFFF, 1);    // past frame end: drains
    add_row(STEP_FLUSH, 16'h5A5A, 0, CHK_NONE, 0, 0);         // nothing pending
    // 2x1 frame: exact halves round toward the odd neighbor
    add_row(STEP_GEOM,  16'd2, 16'd1, CHK_NONE, 0, 0);
    add_row(STEP_PIXEL, 16'd1, 0, CHK_NONE, 0, 0);
    add_row(STEP_FLUSH, 16'd0, 0, CHK_NONE, 0, 0);            // mid-frame, ignored
    add_row(STEP_PIXEL, 16'd2, 0, CHK_NONE, 0, 0);
    add_row(STEP_FLUSH, 16'd0, 0, CHK_VALUE, 16'd1, 0);
    add_row(STEP_FLUSH, 16'd0, 0, CHK_VALUE, 16'd1, 1);
    add_row(STEP_PIXEL, 16'hFFFF, 0, CHK_NONE, 0, 0);
    add_row(STEP_PIXEL, 16'hFFFE, 0, CHK_NONE, 0, 0);
    add_row(STEP_FLUSH, 16'hFFFF, 0, CHK_VALUE, 16'hFFFF, 0);
    add_row(STEP_FLUSH, 16'hFFFF, 0, CHK_VALUE, 16'hFFFF, 1);
    // 3x3 frame cut short by a register write
    add_row(STEP_GEOM,  16'd3, 16'd3, CHK_NONE, 0, 0);
    repeat (4) add_row(STEP_PIXEL, rand_pixel(), 0, CHK_MODEL, 0, 0);
    // 1x3 column: divisors 2, 3, 2
    add_row(STEP_GEOM,  16'd1, 16'd3, CHK_NONE, 0, 0);
    repeat (3) add_row(STEP_PIXEL, rand_pixel(), 0, CHK_MODEL, 0, 0);
    repeat (2) add_row(STEP_FLUSH, rand_pixel(), 0, CHK_MODEL, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        STEP_GEOM:  write_geometry(script[i].a[FW_W-1:0], script[i].b);
        STEP_PIXEL: send(MODE_PIXEL, script[i].a, script[i].chk, script[i].want);
        default:    send(MODE_FLUSH, script[i].a, script[i].chk, script[i].want);
      endcase
    end

    // random part: mostly complete small frames, with a few broken ones
    phase = 0;
    while (items < RANDOM_ITEMS || phase <= 8) begin
      if (items < RANDOM_ITEMS / 3) begin
        src_idle_pct = 25;
        sink_idle_pct = 75;
      end else if (items < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 75;
        sink_idle_pct = 25;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end

      if (phase == 3) begin
        // width above the line buffer depth clamps to MAX_W; feed just past
        // the lag so a few means come out, then leave the frame unfinished
        write_geometry('1, 16'd2);
        repeat (MAX_W + 2 + $urandom_range(6)) begin
          send(MODE_PIXEL, rand_pixel(), CHK_MODEL, NO_RES);
          items++;
        end
      end else if (phase == 8) begin
        // tallest frame, one pixel wide, abandoned early
        write_geometry(11'd1, '1);
        repeat (8 + $urandom_range(40)) begin
          send(MODE_PIXEL, rand_pixel(), CHK_MODEL, NO_RES);
          items++;
        end
      end else begin
        k = $urandom_range(99);
        wr = (k < 10) ? 0 : (k < 70) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        hr = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
        write_geometry(FW_W'(wr), FH_W'(hr));
        ew = (wr == 0) ? 1 : wr;
        eh = (hr == 0) ? 1 : hr;
        n = ew * eh;
        frames = $urandom_range(3, 1);
        repeat (frames) begin
          cut_at = ($urandom_range(99) < 12) ? $urandom_range(n - 1, 0) : n;
          for (k = 0; k < cut_at; k++) begin
            if ($urandom_range(99) < 5)
              send(MODE_FLUSH, rand_pixel(), CHK_MODEL, NO_RES);   // ignored mid-frame
            send(MODE_PIXEL, rand_pixel(), CHK_MODEL, NO_RES);
            items++;
          end
          if (cut_at < n) break;   // broken frame: next write restarts it
          // drain the tail; a pixel here only stands in for a flush
          pend = (n < ew + 1) ? n : ew + 1;
          repeat (pend) begin
            send(($urandom_range(3) == 0) ? MODE_PIXEL : MODE_FLUSH, rand_pixel(),
                 CHK_MODEL, NO_RES);
            items++;
          end
          if ($urandom_range(99) < 20)
            send(MODE_FLUSH, rand_pixel(), CHK_MODEL, NO_RES);     // nothing pending
        end
      end
      phase++;
    end

    // wind down: all means in, then let any trailing work settle
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bs3_pkg.sv
design/bs3_ram.sv
design/box_smooth_3x3_unit.sv
sim/tb_top.sv
